// ===== sv/assert_macros.svh =====
// Assertion macros used by the top RTL file of the facet scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/stlfs_pkg.sv =====
// Package with types, constants and character tables of the facet scanner.
`default_nettype none

package stlfs_pkg;

   localparam int COUNT_WIDTH = 32;

   // Character codes
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   // Token match lengths after the leading letter
   localparam logic [3:0] FACET_TAIL_LEN    = 4'd4;
   localparam logic [3:0] ENDSOLID_TAIL_LEN = 4'd7;

   // Configuration register indexes
   localparam logic CSR_COUNT_FACETS = 1'b0;
   localparam logic CSR_MEASURE_SIZE = 1'b1;

   typedef enum logic [4:0] {
      PH_BETWEEN  = 5'b00001,
      PH_MATCH_F  = 5'b00010,
      PH_MATCH_E  = 5'b00100,
      PH_SKIP     = 5'b01000,
      PH_SEEK_EOL = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] facets_found;
      logic [31:0] byte_count;
      logic        end_found;
   } rsp_type;

   // Letters of "acet" by position
   function automatic logic [7:0] facet_char(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = 8'h61;
         2'd1:    c = 8'h63;
         2'd2:    c = 8'h65;
         default: c = 8'h74;
      endcase
      return c;
   endfunction

   // Letters of "ndsolid" by position
   function automatic logic [7:0] endsolid_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h6E;
         3'd1:    c = 8'h64;
         3'd2:    c = 8'h73;
         3'd3:    c = 8'h6F;
         3'd4:    c = 8'h6C;
         3'd5:    c = 8'h69;
         3'd6:    c = 8'h64;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== sv/stl_ascii_facet_scanner_top.sv =====
// A result is registered at the edge that accepts its byte and shows the next cycle.
// One byte per cycle unless a result waits and is stalled; the result register drains while new bytes arrive.
// The byte classifier and token matcher are one level of logic ahead of the state registers.
// Reset: synchronous, active high; scan state clears, both config bits return to 1.
// A stream re-arms the scanner on its byte marked last.
`default_nettype none
`include "assert_macros.svh"

module stl_ascii_facet_scanner_top
   import stlfs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_index,
   input  wire logic    csr_data
);

   logic                   count_facets_ff;
   logic                   measure_size_ff;
   phase_type              phase_ff, phase_in;
   logic [3:0]             pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0] facets_ff, facets_in;
   logic [COUNT_WIDTH-1:0] bytes_ff, bytes_in;
   logic                   done_ff, done_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic                   req_accept;
   logic                   emit;
   logic                   emit_found;
   logic [COUNT_WIDTH-1:0] emit_bytes;
   logic [COUNT_WIDTH-1:0] emit_facets;
   logic [7:0]             lc;
   logic                   ws;
   logic                   eol;
   rsp_type                result;

   // Stall requests only while a result waits and the consumer holds it
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Classify the incoming byte
   assign ws  = (req_payload.byte_value == CHAR_SPACE) ||
                (req_payload.byte_value inside {[CHAR_TAB:CHAR_CR]});
   assign lc  = (req_payload.byte_value inside {[8'h41:8'h5A]}) ?
                (req_payload.byte_value | CASE_BIT) : req_payload.byte_value;
   assign eol = (req_payload.byte_value == CHAR_LF) || (req_payload.byte_value == CHAR_CR);

   // Advance the scan state for one accepted request
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      facets_in   = facets_ff;
      bytes_in    = bytes_ff;
      done_in     = done_ff;
      emit        = 1'b0;
      emit_found  = 1'b0;
      emit_bytes  = bytes_ff;
      emit_facets = facets_ff;
      if (req_accept) begin
         if (done_ff) begin
            // Drop bytes until the stream ends, then re-arm
            if (req_payload.last) begin
               phase_in  = PH_BETWEEN;
               pos_in    = '0;
               facets_in = '0;
               bytes_in  = '0;
               done_in   = 1'b0;
            end
         end else begin
            case (phase_ff)
               PH_BETWEEN: begin
                  if (ws) begin
                     phase_in = PH_BETWEEN;
                  end else if (lc == CHAR_F) begin
                     phase_in = PH_MATCH_F;
                     pos_in   = '0;
                  end else if (lc == CHAR_E) begin
                     phase_in = PH_MATCH_E;
                     pos_in   = '0;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_MATCH_F: begin
                  if (pos_ff < FACET_TAIL_LEN && lc == facet_char(pos_ff[1:0])) begin
                     pos_in = pos_ff + 4'd1;
                     if (pos_in == FACET_TAIL_LEN) begin
                        if (count_facets_ff && facets_ff != '1) begin
                           facets_in = facets_ff + 1'b1;
                        end
                        phase_in = PH_SKIP;
                     end
                  end else begin
                     phase_in = ws ? PH_BETWEEN : PH_SKIP;
                  end
               end
               PH_MATCH_E: begin
                  if (pos_ff < ENDSOLID_TAIL_LEN && lc == endsolid_char(pos_ff[2:0])) begin
                     pos_in = pos_ff + 4'd1;
                     if (pos_in == ENDSOLID_TAIL_LEN) begin
                        if (measure_size_ff) begin
                           phase_in = PH_SEEK_EOL;
                        end else begin
                           emit       = 1'b1;
                           emit_found = 1'b1;
                           emit_bytes = '0;
                           done_in    = 1'b1;
                        end
                     end
                  end else begin
                     phase_in = ws ? PH_BETWEEN : PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  if (ws) begin
                     phase_in = PH_BETWEEN;
                  end
               end
               PH_SEEK_EOL: begin
                  if (eol) begin
                     emit       = 1'b1;
                     emit_found = 1'b1;
                     emit_bytes = bytes_ff;
                     done_in    = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_BETWEEN;
               end
            endcase

            // Count the byte, saturating
            bytes_in = (bytes_ff == '1) ? bytes_ff : bytes_ff + 1'b1;

            // Close the stream on its final byte
            if (req_payload.last) begin
               emit_facets = facets_in;
               if (!emit) begin
                  emit       = 1'b1;
                  emit_found = (phase_in == PH_SEEK_EOL);
                  emit_bytes = bytes_in;
               end
               phase_in  = PH_BETWEEN;
               pos_in    = '0;
               facets_in = '0;
               bytes_in  = '0;
               done_in   = 1'b0;
            end
         end
      end
   end

   // Form the result from the emitted counts, zeroing those that the config bits switch off
   always_comb begin
      result.facets_found = count_facets_ff ? 32'(emit_facets) : '0;
      result.byte_count   = measure_size_ff ? 32'(emit_bytes) : '0;
      result.end_found    = emit_found;
   end

   // Hold scan state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         count_facets_ff <= 1'b1;
         measure_size_ff <= 1'b1;
         phase_ff        <= PH_BETWEEN;
         pos_ff          <= '0;
         facets_ff       <= '0;
         bytes_ff        <= '0;
         done_ff         <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         facets_ff <= facets_in;
         bytes_ff  <= bytes_in;
         done_ff   <= done_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COUNT_FACETS: count_facets_ff <= csr_data;
               CSR_MEASURE_SIZE: measure_size_ff <= csr_data;
               default:          count_facets_ff <= count_facets_ff;
            endcase
         end
      end
   end

   // Load the result register, drain it when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_IMPLY(a_phase_onehot, 1'b1, $onehot(phase_ff))
   `ASSERT_IMPLY(a_no_result_after_done, done_ff && req_accept, !emit)
   `ASSERT_IMPLY(a_mid_stream_found, emit && !req_payload.last, result.end_found)
   `ASSERT_NEXT(a_result_loaded, emit, rsp_valid_ff && rsp_ff.end_found == $past(emit_found))

endmodule

`default_nettype wire
